FILE: src/bone_influence_top4_normalize_top_macros.svh
// Assertion macros shared by the bone influence limiter modules.
`ifndef BONE_INFLUENCE_TOP4_NORMALIZE_TOP_MACROS_SVH
`define BONE_INFLUENCE_TOP4_NORMALIZE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BITN_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BITN_IMPLY_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bitn_pkg.sv
// Shared types and constants of the bone influence limiter.
package bitn_pkg;

    localparam int unsigned SLOT_CAP     = 4;
    localparam int unsigned KEPT_DEFAULT = 4;
    localparam int unsigned SLOT_IDX_W   = $clog2(SLOT_CAP);
    localparam int unsigned WEIGHT_W     = 16;
    localparam int unsigned BONE_W       = 8;
    localparam int unsigned COUNT_W      = 3;
    localparam int unsigned SUM_W        = 18;
    localparam int unsigned QUOT_W       = 17;
    localparam int unsigned FIFO_DEPTH   = 2;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [BONE_W-1:0]   bone_t;

    // One finished vertex handed from the selection front to the normalizing back.
    typedef struct packed {
        logic [SLOT_CAP-1:0][WEIGHT_W-1:0] weights;
        logic [SLOT_CAP-1:0][BONE_W-1:0]   bones;
        logic [COUNT_W-1:0]                count;
        logic                              pruned;
    } vtx_rec_t;

    // Control from the back sequencer to the divider lanes.
    typedef struct packed {
        logic start;
        logic step;
    } div_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

FILE: src/bitn_in_if.sv
// Input channel carrying one bone influence per transaction.
interface bitn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] bone_index;
    logic [15:0] weight;
    logic       last_influence;

    modport source (output valid, output bone_index, output weight, output last_influence,
                    input ready);
    modport sink (input valid, input bone_index, input weight, input last_influence,
                  output ready);
endinterface

FILE: src/bitn_out_if.sv
// Output channel carrying the kept influences of one vertex per transaction.
interface bitn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] weight_0;
    logic [15:0] weight_1;
    logic [15:0] weight_2;
    logic [15:0] weight_3;
    logic [7:0]  bone_0;
    logic [7:0]  bone_1;
    logic [7:0]  bone_2;
    logic [7:0]  bone_3;
    logic [2:0]  kept_count;
    logic        pruned;

    modport source (output valid, output weight_0, output weight_1, output weight_2,
                    output weight_3, output bone_0, output bone_1, output bone_2,
                    output bone_3, output kept_count, output pruned, input ready);
    modport sink (input valid, input weight_0, input weight_1, input weight_2,
                  input weight_3, input bone_0, input bone_1, input bone_2,
                  input bone_3, input kept_count, input pruned, output ready);
endinterface

FILE: src/bitn_front.sv
// Selection front: keeps the largest influences of the current vertex.
`include "bone_influence_top4_normalize_top_macros.svh"

module bitn_front #(
    parameter int unsigned KEPT_INFLUENCES = bitn_pkg::KEPT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    bitn_in_if.sink           in_ch,
    output bitn_pkg::vtx_rec_t rec,
    output logic              push,
    input  logic              full
);
    import bitn_pkg::*;

    localparam logic [COUNT_W-1:0] KeptCount = COUNT_W'(KEPT_INFLUENCES);

    weight_t          slot_w_reg  [SLOT_CAP];
    weight_t          slot_w_next [SLOT_CAP];
    bone_t            slot_b_reg  [SLOT_CAP];
    bone_t            slot_b_next [SLOT_CAP];
    logic [COUNT_W-1:0] held_reg;
    logic [COUNT_W-1:0] held_next;
    logic             dropped_reg;
    logic             dropped_next;

    logic                  accept;
    logic [SLOT_IDX_W-1:0] victim;
    weight_t               least;
    weight_t               upd_w [SLOT_CAP];
    bone_t                 upd_b [SLOT_CAP];
    logic [COUNT_W-1:0]    upd_held;
    logic                  upd_dropped;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = accept && in_ch.last_influence;

    // Smallest held weight, earliest slot on ties.
    always_comb
    begin
        victim = '0;
        least  = slot_w_reg[0];
        for (int j = 1; j < SLOT_CAP; j++)
        begin
            if ((j < KEPT_INFLUENCES) && (slot_w_reg[j] < least))
            begin
                least  = slot_w_reg[j];
                victim = SLOT_IDX_W'(j);
            end
        end
    end

    // Slot contents after taking the current item.
    always_comb
    begin
        upd_w       = slot_w_reg;
        upd_b       = slot_b_reg;
        upd_held    = held_reg;
        upd_dropped = dropped_reg;
        if (held_reg < KeptCount)
        begin
            upd_w[held_reg[SLOT_IDX_W-1:0]] = in_ch.weight;
            upd_b[held_reg[SLOT_IDX_W-1:0]] = in_ch.bone_index;
            upd_held = held_reg + COUNT_W'(1);
        end
        else
        begin
            upd_dropped = 1'b1;
            // A new item strictly below every held weight is the one dropped.
            if (!(in_ch.weight < least))
            begin
                for (int j = 0; j < SLOT_CAP - 1; j++)
                begin
                    if ((j >= int'(victim)) && (j < KEPT_INFLUENCES - 1))
                    begin
                        upd_w[j] = slot_w_reg[j+1];
                        upd_b[j] = slot_b_reg[j+1];
                    end
                end
                upd_w[KEPT_INFLUENCES-1] = in_ch.weight;
                upd_b[KEPT_INFLUENCES-1] = in_ch.bone_index;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < SLOT_CAP; j++)
        begin
            rec.weights[j] = upd_w[j];
            rec.bones[j]   = upd_b[j];
        end
        rec.count  = upd_held;
        rec.pruned = upd_dropped;
    end

    always_comb
    begin
        slot_w_next  = slot_w_reg;
        slot_b_next  = slot_b_reg;
        held_next    = held_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            if (in_ch.last_influence)
            begin
                for (int j = 0; j < SLOT_CAP; j++)
                begin
                    slot_w_next[j] = '0;
                    slot_b_next[j] = '0;
                end
                held_next    = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                slot_w_next  = upd_w;
                slot_b_next  = upd_b;
                held_next    = upd_held;
                dropped_next = upd_dropped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SLOT_CAP; j++)
            begin
                slot_w_reg[j] <= '0;
                slot_b_reg[j] <= '0;
            end
            held_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            slot_w_reg  <= slot_w_next;
            slot_b_reg  <= slot_b_next;
            held_reg    <= held_next;
            dropped_reg <= dropped_next;
        end
    end

    `BITN_IMPLY(a_held_limit, clk, rst_n, 1'b1, held_reg <= KeptCount,
        "held influence count exceeds the kept limit")
    `BITN_IMPLY(a_drop_full, clk, rst_n, dropped_reg, held_reg == KeptCount,
        "an influence was dropped while slots were still free")
    `BITN_IMPLY_NEXT(a_hold_after_take, clk, rst_n, accept && !in_ch.last_influence,
        held_reg != '0, "no slot held after a non-final influence")

endmodule

FILE: src/bitn_fifo.sv
// Short queue of finished vertices between the selection front and the back.
module bitn_fifo #(
    parameter int unsigned DEPTH = bitn_pkg::FIFO_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bitn_pkg::vtx_rec_t wr_data,
    output logic               full,
    input  logic               pop,
    output bitn_pkg::vtx_rec_t rd_data,
    output logic               empty
);
    import bitn_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    vtx_rec_t          entry_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   cnt_reg;
    logic [CntW-1:0]   cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == CntW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: src/bitn_div.sv
// One restoring divider lane: weight over sum in Q0.16, rounded, one quotient bit a cycle while step is asserted.
module bitn_div (
    input  logic                          clk,
    input  bitn_pkg::div_ctrl_t           ctrl,
    input  logic [bitn_pkg::WEIGHT_W-1:0] weight,
    input  logic [bitn_pkg::SUM_W-1:0]    sum,
    output logic [bitn_pkg::WEIGHT_W-1:0] quotient
);
    import bitn_pkg::*;

    localparam int unsigned DivW = WEIGHT_W + QUOT_W;

    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rem_next;
    logic [QUOT_W-1:0] shf_reg;
    logic [QUOT_W-1:0] shf_next;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;

    logic [DivW-1:0]   dividend;
    logic [SUM_W:0]    trial;
    logic              fits;

    // Adding half the sum before dividing rounds to nearest, halves up.
    assign dividend = {1'b0, weight, {WEIGHT_W{1'b0}}} + DivW'(sum >> 1);
    assign trial    = {rem_reg, shf_reg[QUOT_W-1]};
    assign fits     = (trial >= {1'b0, sum});

    always_comb
    begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        quot_next = quot_reg;
        if (ctrl.start)
        begin
            rem_next  = SUM_W'(dividend[DivW-1:QUOT_W]);
            shf_next  = dividend[QUOT_W-1:0];
            quot_next = '0;
        end
        else if (ctrl.step)
        begin
            rem_next  = fits ? SUM_W'(trial - {1'b0, sum}) : trial[SUM_W-1:0];
            shf_next  = {shf_reg[QUOT_W-2:0], 1'b0};
            quot_next = {quot_reg[QUOT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        shf_reg  <= shf_next;
        quot_reg <= quot_next;
    end

    // A full-scale quotient saturates to the largest Q0.16 value.
    assign quotient = quot_reg[QUOT_W-1] ? '1 : quot_reg[WEIGHT_W-1:0];

endmodule

FILE: src/bitn_back.sv
// Normalizing back: sums the kept weights, divides them when pruned with a nonzero sum, presents the result.
`include "bone_influence_top4_normalize_top_macros.svh"

module bitn_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bitn_pkg::vtx_rec_t rec,
    input  logic               empty,
    output logic               pop,
    bitn_out_if.source         out_ch
);
    import bitn_pkg::*;

    localparam int unsigned DivSteps = QUOT_W;
    localparam int unsigned CntW     = $clog2(DivSteps + 1);

    back_state_t     state_reg;
    back_state_t     state_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    vtx_rec_t        rec_reg;
    vtx_rec_t        rec_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    weight_t         res_w_reg  [SLOT_CAP];
    weight_t         res_w_next [SLOT_CAP];

    logic [SUM_W-1:0] sum_comb;
    logic             normalize;
    div_ctrl_t        div_ctrl;
    weight_t          quot [SLOT_CAP];

    always_comb
    begin
        sum_comb = '0;
        for (int j = 0; j < SLOT_CAP; j++)
        begin
            sum_comb = sum_comb + SUM_W'(rec_reg.weights[j]);
        end
    end

    assign normalize = rec_reg.pruned && (sum_comb != '0);

    for (genvar k = 0; k < SLOT_CAP; k++)
    begin : g_lane
        bitn_div u_div (
            .clk      (clk),
            .ctrl     (div_ctrl),
            .weight   (rec_reg.weights[k]),
            .sum      (sum_reg),
            .quotient (quot[k])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = normalize ? ST_LOAD : ST_OUT;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CntW'(DivSteps))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        pop           = 1'b0;
        div_ctrl      = '0;
        cnt_next      = cnt_reg;
        rec_next      = rec_reg;
        sum_next      = sum_reg;
        res_w_next    = res_w_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pop      = !empty;
                rec_next = rec;
            end
            ST_SUM:
            begin
                sum_next = sum_comb;
                for (int j = 0; j < SLOT_CAP; j++)
                begin
                    res_w_next[j] = rec_reg.weights[j];
                end
            end
            ST_LOAD:
            begin
                div_ctrl.start = 1'b1;
                cnt_next       = '0;
            end
            ST_DIV:
            begin
                if (cnt_reg == CntW'(DivSteps))
                begin
                    res_w_next = quot;
                end
                else
                begin
                    div_ctrl.step = 1'b1;
                    cnt_next      = cnt_reg + CntW'(1);
                end
            end
            ST_OUT:
            begin
                pop = 1'b0;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg   <= rec_next;
        sum_reg   <= sum_next;
        res_w_reg <= res_w_next;
    end

    assign out_ch.valid      = (state_reg == ST_OUT);
    assign out_ch.weight_0   = res_w_reg[0];
    assign out_ch.weight_1   = res_w_reg[1];
    assign out_ch.weight_2   = res_w_reg[2];
    assign out_ch.weight_3   = res_w_reg[3];
    assign out_ch.bone_0     = rec_reg.bones[0];
    assign out_ch.bone_1     = rec_reg.bones[1];
    assign out_ch.bone_2     = rec_reg.bones[2];
    assign out_ch.bone_3     = rec_reg.bones[3];
    assign out_ch.kept_count = rec_reg.count;
    assign out_ch.pruned     = rec_reg.pruned;

    `BITN_IMPLY_NEXT(a_sum_exit, clk, rst_n, state_reg == ST_SUM,
        (state_reg == ST_LOAD) || (state_reg == ST_OUT), "sum state did not advance")
    `BITN_IMPLY(a_div_count, clk, rst_n, state_reg == ST_DIV, cnt_reg <= CntW'(DivSteps),
        "divider step count overran")
    `BITN_IMPLY(a_pass_through, clk, rst_n, (state_reg == ST_OUT) && !rec_reg.pruned,
        (res_w_reg[0] == rec_reg.weights[0]) && (res_w_reg[1] == rec_reg.weights[1]) &&
        (res_w_reg[2] == rec_reg.weights[2]) && (res_w_reg[3] == rec_reg.weights[3]),
        "unpruned weights were altered")

endmodule

FILE: src/bone_influence_top4_normalize_top.sv
// Top level of the bone influence limiter and normalizer.
// Influences of a vertex arrive one per transaction, the last one flagged, and the block
// returns one transaction per vertex with up to KEPT_INFLUENCES kept influences in arrival
// order, the smallest dropped (earliest on ties), unused slots zero. The selection front
// takes one influence every cycle and hands each finished vertex into a two-entry queue.
// The back part passes its idle, sum and output states per vertex when nothing was
// dropped or the kept weights sum to zero; to renormalize it also passes load and divide
// states, in which four divider lanes work in parallel at one quotient bit a cycle, and
// it waits in the output state for the consumer. The front keeps accepting influences
// while the back works, and stalls on any influence while the queue is full.
module bone_influence_top4_normalize_top #(
    parameter int unsigned KEPT_INFLUENCES = bitn_pkg::KEPT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    bitn_in_if.sink     in_ch,
    bitn_out_if.source  out_ch
);
    import bitn_pkg::*;

    vtx_rec_t wr_rec;
    vtx_rec_t rd_rec;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    bitn_front #(
        .KEPT_INFLUENCES (KEPT_INFLUENCES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .rec   (wr_rec),
        .push  (push),
        .full  (full)
    );

    bitn_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_rec),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_rec),
        .empty   (empty)
    );

    bitn_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .rec    (rd_rec),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
